>>> rtl/stereo_gate_compressor_limiter_top_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef STEREO_GATE_COMPRESSOR_LIMITER_TOP_MACROS_SVH
`define STEREO_GATE_COMPRESSOR_LIMITER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SGCL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SGCL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sgcl_pkg.sv
`default_nettype none
package sgcl_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GATE_THRESHOLD   = 3'd0,
      CSR_GATE_HYSTERESIS  = 3'd1,
      CSR_ATTACK_COEF      = 3'd2,
      CSR_RELEASE_COEF     = 3'd3,
      CSR_COMPRESS_THRESH  = 3'd4,
      CSR_COMPRESS_SLOPE   = 3'd5,
      CSR_MAKEUP_GAIN      = 3'd6
   } csr_index_type;

   localparam logic [14:0] COMPRESS_THRESH_RST = 15'd32767;
   localparam logic [15:0] MAKEUP_GAIN_RST     = 16'd4096;
   localparam logic [15:0] UNITY_GAIN_Q412     = 16'd4096;

   localparam logic [15:0] GATE_DECAY  = 16'd64881;
   localparam logic [15:0] GATE_RAMP   = 16'd655;
   localparam logic [15:0] SMOOTH_KEEP = 16'd62259;
   localparam logic [15:0] SMOOTH_TAKE = 16'd3277;

   // Datapath operation for the current sequencer step.
   typedef enum logic [4:0] {
      STEP_NONE     = 5'd0,
      STEP_LOAD     = 5'd1,
      STEP_AMP      = 5'd2,
      STEP_GATE     = 5'd3,
      STEP_GAPPLY_L = 5'd4,
      STEP_GAPPLY_R = 5'd5,
      STEP_FOLLOW_A = 5'd6,
      STEP_FOLLOW_B = 5'd7,
      STEP_ENV      = 5'd8,
      STEP_LOG_ENV  = 5'd9,
      STEP_LOG_THR  = 5'd10,
      STEP_SLOPE    = 5'd11,
      STEP_EXP      = 5'd12,
      STEP_TARGET   = 5'd13,
      STEP_SMOOTH   = 5'd14,
      STEP_SGAIN    = 5'd15,
      STEP_APPLY_L  = 5'd16,
      STEP_APPLY_R  = 5'd17,
      STEP_OUT      = 5'd18
   } step_type;

   typedef struct packed {
      step_type step;
   } dp_cmd_type;

   // Piecewise-linear log2 in Q4.16 of a 16-bit value.
   function automatic logic [19:0] log2_q16(input logic [15:0] x);
      logic [3:0]  e;
      logic [15:0] m;
      logic [31:0] sh;
      e = '0;
      for (int i = 0; i < 16; i++) begin
         if (x[i]) e = 4'(i);
      end
      m  = x & ~(16'd1 << e);
      sh = {m, 16'b0} >> e;
      return {e, sh[15:0]};
   endfunction

endpackage
`default_nettype wire

>>> rtl/sgcl_if.sv
`default_nettype none
interface sgcl_req_if #(parameter int SW = sgcl_pkg::SAMPLE_WIDTH_DEF);
   logic          valid;
   logic          ready;
   logic [SW-1:0] left_in;
   logic [SW-1:0] right_in;
   modport source (output valid, left_in, right_in, input ready);
   modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface sgcl_rsp_if #(parameter int SW = sgcl_pkg::SAMPLE_WIDTH_DEF);
   logic          valid;
   logic          ready;
   logic [SW-1:0] left_out;
   logic [SW-1:0] right_out;
   logic          gate_is_open;
   modport source (output valid, left_out, right_out, gate_is_open, input ready);
   modport sink   (input valid, left_out, right_out, gate_is_open, output ready);
endinterface
`default_nettype wire

>>> rtl/sgcl_ctrl.sv
`default_nettype none
module sgcl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sgcl_pkg::dp_cmd_type      cmd
);

   typedef enum logic [17:0] {
      ST_IDLE     = 18'b000000000000000001,
      ST_AMP      = 18'b000000000000000010,
      ST_GATE     = 18'b000000000000000100,
      ST_GAPPLY_L = 18'b000000000000001000,
      ST_GAPPLY_R = 18'b000000000000010000,
      ST_FOLLOW_A = 18'b000000000000100000,
      ST_FOLLOW_B = 18'b000000000001000000,
      ST_ENV      = 18'b000000000010000000,
      ST_LOG_ENV  = 18'b000000000100000000,
      ST_LOG_THR  = 18'b000000001000000000,
      ST_SLOPE    = 18'b000000010000000000,
      ST_EXP      = 18'b000000100000000000,
      ST_TARGET   = 18'b000001000000000000,
      ST_SMOOTH   = 18'b000010000000000000,
      ST_SGAIN    = 18'b000100000000000000,
      ST_APPLY_L  = 18'b001000000000000000,
      ST_APPLY_R  = 18'b010000000000000000,
      ST_OUT      = 18'b100000000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.step     = sgcl_pkg::STEP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.step = sgcl_pkg::STEP_LOAD;
               state_in = ST_AMP;
            end
         end
         ST_AMP: begin
            cmd.step = sgcl_pkg::STEP_AMP;
            state_in = ST_GATE;
         end
         ST_GATE: begin
            cmd.step = sgcl_pkg::STEP_GATE;
            state_in = ST_GAPPLY_L;
         end
         ST_GAPPLY_L: begin
            cmd.step = sgcl_pkg::STEP_GAPPLY_L;
            state_in = ST_GAPPLY_R;
         end
         ST_GAPPLY_R: begin
            cmd.step = sgcl_pkg::STEP_GAPPLY_R;
            state_in = ST_FOLLOW_A;
         end
         ST_FOLLOW_A: begin
            cmd.step = sgcl_pkg::STEP_FOLLOW_A;
            state_in = ST_FOLLOW_B;
         end
         ST_FOLLOW_B: begin
            cmd.step = sgcl_pkg::STEP_FOLLOW_B;
            state_in = ST_ENV;
         end
         ST_ENV: begin
            cmd.step = sgcl_pkg::STEP_ENV;
            state_in = ST_LOG_ENV;
         end
         ST_LOG_ENV: begin
            cmd.step = sgcl_pkg::STEP_LOG_ENV;
            state_in = ST_LOG_THR;
         end
         ST_LOG_THR: begin
            cmd.step = sgcl_pkg::STEP_LOG_THR;
            state_in = ST_SLOPE;
         end
         ST_SLOPE: begin
            cmd.step = sgcl_pkg::STEP_SLOPE;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            cmd.step = sgcl_pkg::STEP_EXP;
            state_in = ST_TARGET;
         end
         ST_TARGET: begin
            cmd.step = sgcl_pkg::STEP_TARGET;
            state_in = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            cmd.step = sgcl_pkg::STEP_SMOOTH;
            state_in = ST_SGAIN;
         end
         ST_SGAIN: begin
            cmd.step = sgcl_pkg::STEP_SGAIN;
            state_in = ST_APPLY_L;
         end
         ST_APPLY_L: begin
            cmd.step = sgcl_pkg::STEP_APPLY_L;
            state_in = ST_APPLY_R;
         end
         ST_APPLY_R: begin
            cmd.step = sgcl_pkg::STEP_APPLY_R;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.step     = sgcl_pkg::STEP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/sgcl_datapath.sv
`default_nettype none
module sgcl_datapath #(
   parameter int SW = sgcl_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sgcl_pkg::dp_cmd_type              cmd,
   input  wire logic                              csr_we,
   input  wire logic [sgcl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sgcl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [SW-1:0]                     left_in,
   input  wire logic [SW-1:0]                     right_in,
   output logic [SW-1:0]                          left_out,
   output logic [SW-1:0]                          right_out,
   output logic                                   gate_is_open
);

   localparam logic [SW+3:0] SLIMIT = (SW+4)'((99 * (2 ** (SW - 1))) / 100);

   // configuration
   logic [14:0] gthr_ff, ghys_ff, cthr_ff;
   logic [15:0] att_ff, rel_ff, slope_ff, mkup_ff;

   // persistent state
   logic        gate_open_ff, gate_open_in;
   logic [15:0] glevel_ff, glevel_in;
   logic [15:0] sgain_ff, sgain_in;
   logic [15:0] env_ff, env_in;

   // per-frame working registers
   logic          sgn_l_ff, sgn_r_ff;
   logic [SW-1:0] mag_l_ff, mag_l_in, mag_r_ff, mag_r_in;
   logic [15:0]   amp_ff, amp_in;
   logic [15:0]   coef_ff, coef_in;
   logic [32:0]   prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic [19:0]   lg_ff, lg_in, over_ff, over_in, r_ff, r_in;
   logic [16:0]   g_ff, g_in;
   logic [15:0]   target_ff, target_in;
   logic [SW-1:0] out_l_ff, out_r_ff;
   logic          out_gate_ff;

   // combinational helpers
   logic [SW-1:0]    abs_l, abs_r, mag_max, mul_src;
   logic [SW+15:0]   amp_wide, wide_prod;
   logic signed [16:0] close_lvl;
   logic [31:0]      decay_prod;
   logic [16:0]      ramp;
   logic [15:0]      thr_eff;
   logic [33:0]      sum34;
   logic [35:0]      slope_prod;
   logic [17:0]      g_shift;
   logic [4:0]       g_amt;
   logic [SW+3:0]    applied;
   logic [SW-1:0]    clamped;

   assign abs_l     = left_in[SW-1]  ? (~left_in + 1'b1)  : left_in;
   assign abs_r     = right_in[SW-1] ? (~right_in + 1'b1) : right_in;
   assign mag_max   = (mag_l_ff >= mag_r_ff) ? mag_l_ff : mag_r_ff;
   assign amp_wide  = {mag_max, 16'b0} >> SW;
   assign close_lvl = $signed({2'b00, gthr_ff}) - $signed({2'b00, ghys_ff});
   assign decay_prod = 32'(glevel_ff) * 32'(sgcl_pkg::GATE_DECAY);
   assign ramp      = {1'b0, decay_prod[31:16]} + {1'b0, sgcl_pkg::GATE_RAMP};
   assign thr_eff   = (cthr_ff == '0) ? 16'd1 : {1'b0, cthr_ff};
   assign slope_prod = 36'(over_ff) * 36'(slope_ff);
   assign g_amt     = {1'b0, r_ff[19:16]} + 5'd1;
   assign g_shift   = (18'h20000 - {2'b00, r_ff[15:0]}) >> g_amt;

   // shared sample multiplier for gate and gain application
   always_comb begin
      if ((cmd.step == sgcl_pkg::STEP_GAPPLY_L) || (cmd.step == sgcl_pkg::STEP_APPLY_L)) begin
         mul_src = mag_l_ff;
      end else begin
         mul_src = mag_r_ff;
      end
      if ((cmd.step == sgcl_pkg::STEP_GAPPLY_L) || (cmd.step == sgcl_pkg::STEP_GAPPLY_R)) begin
         wide_prod = (SW+16)'(mul_src) * (SW+16)'(glevel_ff);
      end else begin
         wide_prod = (SW+16)'(mul_src) * (SW+16)'(sgain_ff);
      end
      applied = wide_prod[SW+15:12];
      clamped = (applied > SLIMIT) ? SLIMIT[SW-1:0] : applied[SW-1:0];
   end

   always_comb begin
      gate_open_in = gate_open_ff;
      glevel_in    = glevel_ff;
      sgain_in     = sgain_ff;
      env_in       = env_ff;
      mag_l_in     = mag_l_ff;
      mag_r_in     = mag_r_ff;
      amp_in       = amp_ff;
      coef_in      = coef_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      lg_in        = lg_ff;
      over_in      = over_ff;
      r_in         = r_ff;
      g_in         = g_ff;
      target_in    = target_ff;
      sum34        = '0;
      case (cmd.step)
         sgcl_pkg::STEP_LOAD: begin
            mag_l_in = abs_l;
            mag_r_in = abs_r;
         end
         sgcl_pkg::STEP_AMP: begin
            amp_in = amp_wide[15:0];
         end
         sgcl_pkg::STEP_GATE: begin
            if (gate_open_ff) begin
               gate_open_in = !($signed({1'b0, amp_ff}) < close_lvl);
            end else begin
               gate_open_in = (amp_ff > {1'b0, gthr_ff});
            end
            if (gate_open_in) begin
               glevel_in = ramp[16] ? 16'hFFFF : ramp[15:0];
            end else begin
               glevel_in = decay_prod[31:16];
            end
            coef_in = (amp_ff > env_ff) ? att_ff : rel_ff;
         end
         sgcl_pkg::STEP_GAPPLY_L: begin
            if (!gate_open_ff) mag_l_in = wide_prod[SW+15:16];
         end
         sgcl_pkg::STEP_GAPPLY_R: begin
            if (!gate_open_ff) mag_r_in = wide_prod[SW+15:16];
         end
         sgcl_pkg::STEP_FOLLOW_A: begin
            prod_a_in = 33'(coef_ff) * 33'(env_ff);
         end
         sgcl_pkg::STEP_FOLLOW_B: begin
            prod_b_in = (33'h10000 - 33'(coef_ff)) * 33'(amp_ff);
         end
         sgcl_pkg::STEP_ENV: begin
            sum34  = 34'(prod_a_ff) + 34'(prod_b_ff) + 34'd32768;
            env_in = sum34[31:16];
         end
         sgcl_pkg::STEP_LOG_ENV: begin
            lg_in = sgcl_pkg::log2_q16(env_ff);
         end
         sgcl_pkg::STEP_LOG_THR: begin
            over_in = lg_ff - sgcl_pkg::log2_q16(thr_eff);
         end
         sgcl_pkg::STEP_SLOPE: begin
            r_in = slope_prod[35:16];
         end
         sgcl_pkg::STEP_EXP: begin
            g_in = (env_ff > thr_eff) ? g_shift[16:0] : 17'h10000;
         end
         sgcl_pkg::STEP_TARGET: begin
            sum34     = 34'(g_ff) * 34'(mkup_ff) + 34'd32768;
            target_in = sum34[31:16];
         end
         sgcl_pkg::STEP_SMOOTH: begin
            prod_a_in = 33'(sgain_ff) * 33'(sgcl_pkg::SMOOTH_KEEP);
         end
         sgcl_pkg::STEP_SGAIN: begin
            sum34    = 34'(prod_a_ff) + 34'(target_ff) * 34'(sgcl_pkg::SMOOTH_TAKE)
                       + 34'd32768;
            sgain_in = sum34[31:16];
         end
         sgcl_pkg::STEP_APPLY_L: begin
            mag_l_in = clamped;
         end
         sgcl_pkg::STEP_APPLY_R: begin
            mag_r_in = clamped;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gthr_ff      <= '0;
         ghys_ff      <= '0;
         att_ff       <= '0;
         rel_ff       <= '0;
         cthr_ff      <= sgcl_pkg::COMPRESS_THRESH_RST;
         slope_ff     <= '0;
         mkup_ff      <= sgcl_pkg::MAKEUP_GAIN_RST;
         gate_open_ff <= 1'b0;
         glevel_ff    <= '0;
         sgain_ff     <= sgcl_pkg::UNITY_GAIN_Q412;
         env_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (sgcl_pkg::csr_index_type'(csr_index))
               sgcl_pkg::CSR_GATE_THRESHOLD:  gthr_ff  <= csr_wdata[14:0];
               sgcl_pkg::CSR_GATE_HYSTERESIS: ghys_ff  <= csr_wdata[14:0];
               sgcl_pkg::CSR_ATTACK_COEF:     att_ff   <= csr_wdata;
               sgcl_pkg::CSR_RELEASE_COEF:    rel_ff   <= csr_wdata;
               sgcl_pkg::CSR_COMPRESS_THRESH: cthr_ff  <= csr_wdata[14:0];
               sgcl_pkg::CSR_COMPRESS_SLOPE:  slope_ff <= csr_wdata;
               sgcl_pkg::CSR_MAKEUP_GAIN:     mkup_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         gate_open_ff <= gate_open_in;
         glevel_ff    <= glevel_in;
         sgain_ff     <= sgain_in;
         env_ff       <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_l_ff  <= mag_l_in;
      mag_r_ff  <= mag_r_in;
      amp_ff    <= amp_in;
      coef_ff   <= coef_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      lg_ff     <= lg_in;
      over_ff   <= over_in;
      r_ff      <= r_in;
      g_ff      <= g_in;
      target_ff <= target_in;
      if (cmd.step == sgcl_pkg::STEP_LOAD) begin
         sgn_l_ff <= left_in[SW-1];
         sgn_r_ff <= right_in[SW-1];
      end
      if (cmd.step == sgcl_pkg::STEP_OUT) begin
         out_l_ff    <= sgn_l_ff ? (~mag_l_ff + 1'b1) : mag_l_ff;
         out_r_ff    <= sgn_r_ff ? (~mag_r_ff + 1'b1) : mag_r_ff;
         out_gate_ff <= gate_open_ff;
      end
   end

   assign left_out     = out_l_ff;
   assign right_out    = out_r_ff;
   assign gate_is_open = out_gate_ff;

endmodule
`default_nettype wire

>>> rtl/stereo_gate_compressor_limiter_top.sv
`default_nettype none
// Stereo noise gate, compressor and limiter. A frame is taken when req_ch.ready is high,
// which is only while the sequencer is idle; the sequencer then walks the gate, envelope
// follower, log/exp gain computer, gain smoother and output stage one step per state,
// and the result appears on rsp_ch in the same cycle as the block turns ready for a new
// frame, so a frame is not taken before the last one is finished.
// A finished result waits in the output register while the next frame is worked on;
// if it is still not taken, the block holds at the last step.
module stereo_gate_compressor_limiter_top #(
   parameter int SAMPLE_WIDTH = sgcl_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   sgcl_req_if.sink                               req_ch,
   sgcl_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [sgcl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sgcl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   sgcl_pkg::dp_cmd_type cmd;

   sgcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   sgcl_datapath #(.SW(SAMPLE_WIDTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .left_in      (req_ch.left_in),
      .right_in     (req_ch.right_in),
      .left_out     (rsp_ch.left_out),
      .right_out    (rsp_ch.right_out),
      .gate_is_open (rsp_ch.gate_is_open)
   );

endmodule
`default_nettype wire

>>> rtl/sgcl_checker.sv
`default_nettype none
`include "stereo_gate_compressor_limiter_top_macros.svh"
module sgcl_checker #(
   parameter int SW = sgcl_pkg::SAMPLE_WIDTH_DEF
) (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          req_valid,
   input wire logic          req_ready,
   input wire logic          rsp_valid,
   input wire logic          rsp_ready,
   input wire logic [SW-1:0] left_out,
   input wire logic [SW-1:0] right_out
);

   localparam int LIM = (99 * (2 ** (SW - 1))) / 100;

   `SGCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")
   `SGCL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "second word taken while busy")
   `SGCL_ASSERT_NOW(a_out_clamped, clock, reset, rsp_valid, ($signed(left_out) <= LIM) && ($signed(left_out) >= -LIM) && ($signed(right_out) <= LIM) && ($signed(right_out) >= -LIM), "output beyond limiter bound")

endmodule

bind stereo_gate_compressor_limiter_top sgcl_checker #(.SW(SAMPLE_WIDTH)) u_sgcl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .left_out  (rsp_ch.left_out),
   .right_out (rsp_ch.right_out)
);
`default_nettype wire
